>>> rtl/vad_pkg.sv
package vad_pkg;

  // Input beat: one window probability or an end-of-stream marker
  typedef struct packed {
    logic        mode;
    logic [15:0] speech_prob;
    logic [31:0] total_samples;
  } item_t;

  // Classified item as it waits between front and back
  typedef struct packed {
    logic        mode;
    logic        speech;
    logic        quiet;
    logic [31:0] total_samples;
  } cls_t;

  // Result beat: one padded speech segment
  typedef struct packed {
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic        last_of_run;
  } result_t;

  // Configuration register file
  typedef struct packed {
    logic [15:0] speech_threshold;
    logic [31:0] min_speech_len;
    logic [31:0] max_speech_len;
    logic [31:0] min_silence_len;
    logic [31:0] split_silence_len;
    logic [15:0] pad_len;
    logic [15:0] window_len;
  } cfg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEECH_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEECH_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEECH_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SILENCE_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_SILENCE_LEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEN           = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN        = 3'd6;

  // Reset values
  localparam logic [15:0] RST_SPEECH_THRESHOLD  = 16'd32768;
  localparam logic [31:0] RST_MIN_SPEECH_LEN    = 32'd4000;
  localparam logic [31:0] RST_MAX_SPEECH_LEN    = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_MIN_SILENCE_LEN   = 32'd1600;
  localparam logic [31:0] RST_SPLIT_SILENCE_LEN = 32'd1568;
  localparam logic [15:0] RST_PAD_LEN           = 16'd480;
  localparam logic [15:0] RST_WINDOW_LEN        = 16'd512;

  // 0.15 in Q0.16, rounded: silence sits this far below the speech threshold
  localparam logic [15:0] SIL_OFFSET = 16'd9830;

endpackage

>>> rtl/vad_fifo.sv
module vad_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  // Storage, no reset on payload
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/vad_front.sv
module vad_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  vad_pkg::item_t      item,
  input  logic [15:0]         threshold,
  input  logic                pop,
  output vad_pkg::cls_t       head,
  output logic                empty
);

  localparam int QUEUE_DEPTH = 2;

  vad_pkg::cls_t                     cls;
  logic [$bits(vad_pkg::cls_t)-1:0]  head_bits;
  logic [16:0]                       quiet_sum;

  // Classify the window: speech at threshold, silence below threshold - 0.15
  assign quiet_sum        = {1'b0, item.speech_prob} + {1'b0, vad_pkg::SIL_OFFSET};
  assign cls.mode          = item.mode;
  assign cls.speech        = (item.speech_prob >= threshold);
  assign cls.quiet         = (quiet_sum < {1'b0, threshold});
  assign cls.total_samples = item.total_samples;

  vad_fifo #(
    .WIDTH ($bits(vad_pkg::cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cls),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head_bits),
    .empty   (empty),
    .count   ()
  );

  assign head = vad_pkg::cls_t'(head_bits);

endmodule

>>> rtl/vad_back.sv
module vad_back #(
  parameter int POS_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  vad_pkg::cfg_t     cfg,
  input  logic              in_empty,
  input  vad_pkg::cls_t     in_head,
  output logic              in_pop,
  input  logic              out_room,
  output logic              out_push,
  output vad_pkg::result_t  out_data
);

  localparam int VW = (POS_BITS > 32) ? POS_BITS : 32;
  localparam logic [VW-1:0] PosMax = VW'((65'd1 << POS_BITS) - 65'd1);

  // Sequencer steps
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_W0   = 4'd1;
  localparam logic [3:0] S_W1   = 4'd2;
  localparam logic [3:0] S_Q    = 4'd3;
  localparam logic [3:0] S_P0   = 4'd4;
  localparam logic [3:0] S_P1   = 4'd5;
  localparam logic [3:0] S_F0   = 4'd6;
  localparam logic [3:0] S_F1   = 4'd7;
  localparam logic [3:0] S_FL   = 4'd8;

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a > PosMax || s > {1'b0, PosMax}) begin
      sat_add = PosMax;
    end else begin
      sat_add = s[VW-1:0];
    end
  endfunction

  function automatic logic [VW-1:0] floor_sub(input logic [VW-1:0] a, input logic [VW-1:0] b);
    floor_sub = (a > b) ? a - b : '0;
  endfunction

  logic [3:0]    state, state_next;
  logic [3:0]    ret, ret_next;
  logic          trig, trig_next;
  logic          hv, hv_next;
  logic          pend_v, pend_v_next;
  logic [VW-1:0] wpos, wpos_next;
  logic [VW-1:0] os, os_next;
  logic [VW-1:0] te, te_next;
  logic [VW-1:0] se, se_next;
  logic [VW-1:0] rs, rs_next;

  logic [VW-1:0] hs, hs_next;
  logic [VW-1:0] he, he_next;
  logic [VW-1:0] ps, ps_next;
  logic [VW-1:0] pe, pe_next;
  logic [VW-1:0] pos_r, pos_next;
  logic [VW-1:0] tot, tot_next;
  logic [VW-1:0] dif, dif_next;
  logic          ge, ge_next;
  logic          speech, speech_next;
  logic          quiet, quiet_next;
  logic [31:0]   pend_s, pend_s_next;
  logic [31:0]   pend_e, pend_e_next;

  logic [VW-1:0] pad;
  logic [VW-1:0] te_eff;
  logic [VW-1:0] sil_run;
  logic [VW-1:0] te_len;
  logic          q_keep;
  logic          over;
  logic [VW-1:0] amt;
  logic [VW-1:0] half;
  logic [VW-1:0] he_pad;
  logic [VW-1:0] s_pad;
  logic [VW-1:0] fin_end;
  logic [VW-1:0] open_len;
  logic          run_q;
  logic          go_ret;
  logic          done;
  logic          emit_v;
  logic [31:0]   emit_s;
  logic [31:0]   emit_e;

  assign pad = VW'(cfg.pad_len);

  // Silence run and segment length for the closing check
  assign te_eff   = (te == '0) ? pos_r : te;
  assign sil_run  = floor_sub(pos_r, te_eff);
  assign te_len   = te_eff - os;
  assign q_keep   = (te_eff > os) && (te_len > VW'(cfg.min_speech_len));
  assign over     = trig && (floor_sub(pos_r, os) > VW'(cfg.max_speech_len));

  // Gap padding between held segment and new one
  assign amt    = (dif < VW'({cfg.pad_len, 1'b0})) ? (dif >> 1) : pad;
  assign half   = (dif >> 1) + VW'(dif[0]);
  assign he_pad = ge ? sat_add(he, amt) : he - half;
  assign s_pad  = ge ? floor_sub(ps, amt) : sat_add(ps, half);

  // End of stream: held end padded and clamped to the stream length
  assign fin_end  = (sat_add(he, pad) > tot) ? tot : sat_add(he, pad);
  assign open_len = tot - os;

  always_comb begin
    state_next  = state;
    ret_next    = ret;
    trig_next   = trig;
    hv_next     = hv;
    pend_v_next = pend_v;
    wpos_next   = wpos;
    os_next     = os;
    te_next     = te;
    se_next     = se;
    rs_next     = rs;
    hs_next     = hs;
    he_next     = he;
    ps_next     = ps;
    pe_next     = pe;
    pos_next    = pos_r;
    tot_next    = tot;
    dif_next    = dif;
    ge_next     = ge;
    speech_next = speech;
    quiet_next  = quiet;
    pend_s_next = pend_s;
    pend_e_next = pend_e;
    in_pop      = 1'b0;
    out_push    = 1'b0;
    out_data    = '0;
    run_q       = 1'b0;
    go_ret      = 1'b0;
    done        = 1'b0;
    emit_v      = 1'b0;
    emit_s      = '0;
    emit_e      = '0;

    case (state)
      // Take the next item once the result queue has room for two beats
      S_IDLE: begin
        if (!in_empty && out_room) begin
          in_pop      = 1'b1;
          speech_next = in_head.speech;
          quiet_next  = in_head.quiet;
          tot_next    = VW'(in_head.total_samples);
          pos_next    = wpos;
          state_next  = in_head.mode ? S_F0 : S_W0;
        end
      end
      // Window: advance position, resume speech, open, or check length
      S_W0: begin
        wpos_next = sat_add(wpos, VW'(cfg.window_len));
        if (speech && te != '0) begin
          te_next = '0;
          if (rs < se) begin
            rs_next = pos_r;
          end
        end
        if (speech && !trig) begin
          trig_next = 1'b1;
          os_next   = pos_r;
          done      = 1'b1;
        end else if (over) begin
          state_next = S_W1;
        end else begin
          run_q = 1'b1;
        end
      end
      // Forced split of overlong speech
      S_W1: begin
        ps_next = os;
        te_next = '0;
        se_next = '0;
        rs_next = '0;
        if (se != '0) begin
          pe_next = se;
          if (rs < se) begin
            trig_next = 1'b0;
            os_next   = '0;
          end else begin
            os_next = rs;
          end
          ret_next = S_Q;
        end else begin
          pe_next   = pos_r;
          trig_next = 1'b0;
          os_next   = '0;
          ret_next  = S_IDLE;
        end
        state_next = S_P0;
      end
      S_Q: begin
        run_q = 1'b1;
      end
      // Produce: first segment only gets its start padded
      S_P0: begin
        if (!hv) begin
          hs_next = floor_sub(ps, pad);
          he_next = pe;
          hv_next = 1'b1;
          go_ret  = 1'b1;
        end else begin
          ge_next    = (ps >= he);
          dif_next   = (ps >= he) ? ps - he : he - ps;
          state_next = S_P1;
        end
      end
      // Produce: emit held segment, hold the new one
      S_P1: begin
        emit_v  = 1'b1;
        emit_s  = hs[31:0];
        emit_e  = he_pad[31:0];
        hs_next = s_pad;
        he_next = pe;
        go_ret  = 1'b1;
      end
      // End of stream: close the open segment if long enough
      S_F0: begin
        if (os != '0 && tot > os && open_len > VW'(cfg.min_speech_len)) begin
          ps_next    = os;
          pe_next    = tot;
          ret_next   = S_F1;
          state_next = S_P0;
        end else begin
          state_next = S_F1;
        end
      end
      // End of stream: flush the held segment and clear state
      S_F1: begin
        if (hv) begin
          emit_v = 1'b1;
          emit_s = hs[31:0];
          emit_e = fin_end[31:0];
        end
        trig_next = 1'b0;
        hv_next   = 1'b0;
        wpos_next = '0;
        os_next   = '0;
        te_next   = '0;
        se_next   = '0;
        rs_next   = '0;
        done      = 1'b1;
      end
      // Last beat of the item
      S_FL: begin
        out_push    = 1'b1;
        out_data    = '{seg_start: pend_s, seg_end: pend_e, last_of_run: 1'b1};
        pend_v_next = 1'b0;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Silence tracking and segment close
    if (run_q) begin
      if (quiet && trig) begin
        if (sil_run > VW'(cfg.split_silence_len)) begin
          se_next = te_eff;
        end
        if (sil_run >= VW'(cfg.min_silence_len)) begin
          se_next   = '0;
          rs_next   = '0;
          te_next   = '0;
          trig_next = 1'b0;
          os_next   = '0;
          if (q_keep) begin
            ps_next    = os;
            pe_next    = te_eff;
            ret_next   = S_IDLE;
            state_next = S_P0;
          end else begin
            done = 1'b1;
          end
        end else begin
          te_next = te_eff;
          done    = 1'b1;
        end
      end else begin
        done = 1'b1;
      end
    end

    if (go_ret) begin
      if (ret == S_IDLE) begin
        done = 1'b1;
      end else begin
        state_next = ret;
      end
    end

    // One beat stays pending so the final one can carry last_of_run
    if (emit_v) begin
      if (pend_v) begin
        out_push = 1'b1;
        out_data = '{seg_start: pend_s, seg_end: pend_e, last_of_run: 1'b0};
      end
      pend_v_next = 1'b1;
      pend_s_next = emit_s;
      pend_e_next = emit_e;
    end

    if (done) begin
      state_next = pend_v_next ? S_FL : S_IDLE;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret    <= S_IDLE;
      trig   <= 1'b0;
      hv     <= 1'b0;
      pend_v <= 1'b0;
      wpos   <= '0;
      os     <= '0;
      te     <= '0;
      se     <= '0;
      rs     <= '0;
    end else begin
      state  <= state_next;
      ret    <= ret_next;
      trig   <= trig_next;
      hv     <= hv_next;
      pend_v <= pend_v_next;
      wpos   <= wpos_next;
      os     <= os_next;
      te     <= te_next;
      se     <= se_next;
      rs     <= rs_next;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    hs     <= hs_next;
    he     <= he_next;
    ps     <= ps_next;
    pe     <= pe_next;
    pos_r  <= pos_next;
    tot    <= tot_next;
    dif    <= dif_next;
    ge     <= ge_next;
    speech <= speech_next;
    quiet  <= quiet_next;
    pend_s <= pend_s_next;
    pend_e <= pend_e_next;
  end

endmodule

>>> rtl/vad_speech_segmenter.sv
// Speech segmenter over per-window speech probabilities.
// Input queue side: drive item and push; a beat is taken when push is high
// and full is low. mode 0 carries one window probability (Q0.16), mode 1
// ends the stream with its total length in samples.
// Result queue side: while empty is low the oldest segment is on result;
// pop takes it. Each item yields zero, one or two segment beats, the last
// one flagged by last_of_run. Config writes (cfg_wr, cfg_idx, cfg_data)
// take effect at once and belong in idle periods.
// Flow: a window that closes no segment passes dispatch and evaluate in
// the back end (S_IDLE, S_W0), which finishes one item before it takes the
// next. A segment adds gap padding (S_P0, plus S_P1 once one is held) and
// a step to hand out the last beat (S_FL); a forced split adds S_W1, and
// S_Q when it splits at a pause. The back end only starts an item when the
// 4-beat result queue has room for two beats, so a stalled receiver fills
// that queue, then the 2-beat input queue, and then full rises.
// Reset clears segment state and position and loads the default config.
module vad_speech_segmenter #(
  parameter int POS_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  vad_pkg::item_t                  item,
  output logic                            empty,
  input  logic                            pop,
  output vad_pkg::result_t                result,
  input  logic                            cfg_wr,
  input  logic [vad_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [vad_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);

  vad_pkg::cfg_t                        cfg;
  vad_pkg::cls_t                        head;
  logic                                 mid_empty;
  logic                                 mid_pop;
  logic                                 out_push;
  vad_pkg::result_t                     out_data;
  logic [$bits(vad_pkg::result_t)-1:0]  res_bits;
  logic [OUT_CNT_W-1:0]                 out_cnt;
  logic                                 out_room;
  logic                                 out_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speech_threshold  <= vad_pkg::RST_SPEECH_THRESHOLD;
      cfg.min_speech_len    <= vad_pkg::RST_MIN_SPEECH_LEN;
      cfg.max_speech_len    <= vad_pkg::RST_MAX_SPEECH_LEN;
      cfg.min_silence_len   <= vad_pkg::RST_MIN_SILENCE_LEN;
      cfg.split_silence_len <= vad_pkg::RST_SPLIT_SILENCE_LEN;
      cfg.pad_len           <= vad_pkg::RST_PAD_LEN;
      cfg.window_len        <= vad_pkg::RST_WINDOW_LEN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        vad_pkg::CFG_SPEECH_THRESHOLD:  cfg.speech_threshold  <= cfg_data[15:0];
        vad_pkg::CFG_MIN_SPEECH_LEN:    cfg.min_speech_len    <= cfg_data;
        vad_pkg::CFG_MAX_SPEECH_LEN:    cfg.max_speech_len    <= cfg_data;
        vad_pkg::CFG_MIN_SILENCE_LEN:   cfg.min_silence_len   <= cfg_data;
        vad_pkg::CFG_SPLIT_SILENCE_LEN: cfg.split_silence_len <= cfg_data;
        vad_pkg::CFG_PAD_LEN:           cfg.pad_len           <= cfg_data[15:0];
        vad_pkg::CFG_WINDOW_LEN:        cfg.window_len        <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  vad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .threshold (cfg.speech_threshold),
    .pop       (mid_pop),
    .head      (head),
    .empty     (mid_empty)
  );

  // Room for a full item's worth of beats
  assign out_room = (out_cnt <= OUT_CNT_W'(OUT_DEPTH-2));

  vad_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_empty (mid_empty),
    .in_head  (head),
    .in_pop   (mid_pop),
    .out_room (out_room),
    .out_push (out_push),
    .out_data (out_data)
  );

  vad_fifo #(
    .WIDTH ($bits(vad_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_data),
    .full    (out_full),
    .rd_en   (pop && !out_full | pop),
    .rd_data (res_bits),
    .empty   (empty),
    .count   (out_cnt)
  );

  assign result = vad_pkg::result_t'(res_bits);

endmodule

>>> tb/vad_speech_segmenter_tb.sv
module vad_speech_segmenter_tb;

  localparam int          POS_BITS   = 32;
  localparam bit [63:0]   POS_MAX    = (64'd1 << POS_BITS) - 64'd1;
  localparam int          DRAIN_WAIT = 20;
  localparam int          LONG_STALL = 300;
  localparam int          STALL_LIMIT = 3000;
  localparam logic        MODE_WINDOW = 1'b0;
  localparam logic        MODE_FINISH = 1'b1;

  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_t;

  logic    clk;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    full;
  vad_pkg::item_t   item = '0;
  logic    empty;
  logic    pop = 1'b0;
  vad_pkg::result_t result;
  logic                           cfg_wr = 1'b0;
  logic [vad_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [vad_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  vad_speech_segmenter #(.POS_BITS(POS_BITS)) uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_wr(cfg_wr), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // stimulus and expectation stores
  vad_pkg::item_t   beats_to_send[$];
  vad_pkg::result_t segs_due[$];
  int      seg_errors = 0;
  int      idle_cycles = 0;
  idle_t   idle_mode = IDLE_NONE;
  bit      stall_req = 1'b0;
  bit      stall_ack = 1'b0;
  int      stall_left = 0;

  // segmenter state as the predictor sees it
  vad_pkg::cfg_t model_cfg = '{
    speech_threshold: vad_pkg::RST_SPEECH_THRESHOLD,
    min_speech_len: vad_pkg::RST_MIN_SPEECH_LEN,
    max_speech_len: vad_pkg::RST_MAX_SPEECH_LEN,
    min_silence_len: vad_pkg::RST_MIN_SILENCE_LEN,
    split_silence_len: vad_pkg::RST_SPLIT_SILENCE_LEN,
    pad_len: vad_pkg::RST_PAD_LEN,
    window_len: vad_pkg::RST_WINDOW_LEN};
  bit        in_speech = 1'b0;
  bit        hold_valid = 1'b0;
  bit [63:0] cur_pos = '0;
  bit [63:0] open_pos = '0;
  bit [63:0] quiet_from = '0;
  bit [63:0] split_pos = '0;
  bit [63:0] resume_pos = '0;
  bit [63:0] hold_start = '0;
  bit [63:0] hold_end = '0;
  vad_pkg::result_t seg_run[2];
  int        seg_run_len = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic bit [63:0] sat_pos_add(bit [63:0] a, bit [63:0] b);
    if (a > POS_MAX || b > POS_MAX - a) return POS_MAX;
    return a + b;
  endfunction

  function automatic bit [63:0] sub_floor(bit [63:0] a, bit [63:0] b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  function automatic void emit_seg(bit [63:0] s, bit [63:0] e);
    if (seg_run_len < 2) begin
      seg_run[seg_run_len].seg_start   = s[31:0];
      seg_run[seg_run_len].seg_end     = e[31:0];
      seg_run[seg_run_len].last_of_run = 1'b0;
      seg_run_len++;
    end
  endfunction

  // new raw segment: pad the gap against the held one, release that, hold this
  function automatic void hand_over(bit [63:0] s, bit [63:0] e);
    bit [63:0] pad;
    bit [63:0] he;
    bit [63:0] gap;
    bit [63:0] half;
    pad = 64'(model_cfg.pad_len);
    if (!hold_valid) begin
      s = sub_floor(s, pad);
    end else begin
      he = hold_end;
      if (s >= he) begin
        gap = s - he;
        if (gap < 2 * pad) begin
          he = sat_pos_add(he, gap / 2);
          s  = sub_floor(s, gap / 2);
        end else begin
          he = sat_pos_add(he, pad);
          s  = sub_floor(s, pad);
        end
      end else begin
        // overlap: both sides give up the rounded-up half
        gap  = he - s;
        half = gap / 2 + 64'(gap[0]);
        he   = he - half;
        s    = sat_pos_add(s, half);
      end
      emit_seg(hold_start, he);
    end
    hold_start = s;
    hold_end   = e;
    hold_valid = 1'b1;
  endfunction

  function automatic void clear_stream();
    in_speech  = 1'b0;
    hold_valid = 1'b0;
    cur_pos    = '0;
    open_pos   = '0;
    quiet_from = '0;
    split_pos  = '0;
    resume_pos = '0;
    hold_start = '0;
    hold_end   = '0;
  endfunction

  function automatic void drop_markers();
    split_pos  = '0;
    resume_pos = '0;
    quiet_from = '0;
  endfunction

  function automatic void step_window(bit [15:0] prob);
    bit [63:0] pos;
    bit        speech;
    bit        quiet;
    bit        done;
    pos    = cur_pos;
    speech = 64'(prob) >= 64'(model_cfg.speech_threshold);
    quiet  = 64'(prob) + 64'(vad_pkg::SIL_OFFSET) < 64'(model_cfg.speech_threshold);
    done   = 1'b0;
    // speech back after a pause cancels the pending end
    if (speech && quiet_from > 0) begin
      quiet_from = '0;
      if (resume_pos < split_pos) resume_pos = pos;
    end
    if (speech && !in_speech) begin
      in_speech = 1'b1;
      open_pos  = pos;
      done      = 1'b1;
    end
    // over-long speech: split at the last long pause, else right here
    if (!done && in_speech &&
        sub_floor(pos, open_pos) > 64'(model_cfg.max_speech_len)) begin
      if (split_pos > 0) begin
        hand_over(open_pos, split_pos);
        if (resume_pos < split_pos) begin
          in_speech = 1'b0;
          open_pos  = '0;
        end else begin
          open_pos = resume_pos;
        end
        drop_markers();
      end else begin
        hand_over(open_pos, pos);
        drop_markers();
        in_speech = 1'b0;
        open_pos  = '0;
        done      = 1'b1;
      end
    end
    // silence tracking and segment close
    if (!done && quiet && in_speech) begin
      if (quiet_from == 0) quiet_from = pos;
      if (sub_floor(pos, quiet_from) > 64'(model_cfg.split_silence_len))
        split_pos = quiet_from;
      if (sub_floor(pos, quiet_from) >= 64'(model_cfg.min_silence_len)) begin
        if (quiet_from > open_pos &&
            quiet_from - open_pos > 64'(model_cfg.min_speech_len))
          hand_over(open_pos, quiet_from);
        drop_markers();
        in_speech = 1'b0;
        open_pos  = '0;
      end
    end
    cur_pos = sat_pos_add(cur_pos, 64'(model_cfg.window_len));
  endfunction

  function automatic void close_stream(bit [31:0] total);
    bit [63:0] tot;
    bit [63:0] e;
    tot = 64'(total);
    if (open_pos > 0 && tot > open_pos &&
        tot - open_pos > 64'(model_cfg.min_speech_len))
      hand_over(open_pos, tot);
    if (hold_valid) begin
      e = sat_pos_add(hold_end, 64'(model_cfg.pad_len));
      if (e > tot) e = tot;
      emit_seg(hold_start, e);
    end
    clear_stream();
  endfunction

  function automatic void advance_model(vad_pkg::item_t it);
    vad_pkg::result_t r;
    seg_run_len = 0;
    if (it.mode == MODE_FINISH) close_stream(it.total_samples);
    else step_window(it.speech_prob);
    for (int i = 0; i < seg_run_len; i++) begin
      r = seg_run[i];
      r.last_of_run = (i == seg_run_len - 1);
      segs_due.push_back(r);
    end
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic bit roll(int pct);
    return pct > 0 && $urandom_range(99) < pct;
  endfunction

  function automatic int tx_idle_pct();
    return (idle_mode == IDLE_TX) ? 52 : (idle_mode == IDLE_BOTH) ? 12 : 0;
  endfunction

  function automatic int rx_idle_pct();
    return (idle_mode == IDLE_RX) ? 52 : (idle_mode == IDLE_BOTH) ? 12 : 0;
  endfunction

  function automatic vad_pkg::cfg_t make_cfg(bit [15:0] thr, bit [31:0] min_sp,
                                             bit [31:0] max_sp, bit [31:0] min_sil,
                                             bit [31:0] split_sil,
                                             bit [15:0] pad, bit [15:0] win);
    vad_pkg::cfg_t c;
    c.speech_threshold  = thr;
    c.min_speech_len    = min_sp;
    c.max_speech_len    = max_sp;
    c.min_silence_len   = min_sil;
    c.split_silence_len = split_sil;
    c.pad_len           = pad;
    c.window_len        = win;
    return c;
  endfunction

  function automatic vad_pkg::cfg_t rand_cfg();
    return make_cfg(16'($urandom_range(60000, 15000)), $urandom_range(6000),
                    $urandom_range(1) ? 32'hFFFF_FFFF : $urandom_range(30000, 2000),
                    $urandom_range(4000), $urandom_range(4000),
                    16'($urandom_range(1200)), 16'($urandom_range(1024, 64)));
  endfunction

  function automatic void push_window(bit [15:0] prob);
    vad_pkg::item_t it;
    it.mode          = MODE_WINDOW;
    it.speech_prob   = prob;
    it.total_samples = $urandom();
    beats_to_send.push_back(it);
  endfunction

  function automatic void push_finish(bit [31:0] total);
    vad_pkg::item_t it;
    it.mode          = MODE_FINISH;
    it.speech_prob   = 16'($urandom_range(65535));
    it.total_samples = total;
    beats_to_send.push_back(it);
  endfunction

  // probability for a run kind: speech, silence, anything, or a threshold edge
  function automatic bit [15:0] pick_prob(int kind);
    bit [31:0] thr;
    bit [31:0] sil;
    thr = 32'(model_cfg.speech_threshold);
    sil = 32'(vad_pkg::SIL_OFFSET);
    if (kind < 45) return (thr == 0) ? 16'($urandom_range(65535))
                                     : 16'($urandom_range(65535, thr));
    if (kind < 85) return (thr > sil) ? 16'($urandom_range(thr - sil - 32'd1, 0))
                                      : 16'($urandom_range(65535));
    if (kind < 95) return 16'($urandom_range(65535));
    case ($urandom_range(2))
      0:       return 16'(thr);
      1:       return 16'(thr - sil);
      default: return 16'(thr - sil - 32'd1);
    endcase
  endfunction

  // one stream: runs of speech and silence, then an end-of-stream beat
  function automatic int queue_stream();
    int        target;
    int        n;
    int        len;
    int        kind;
    bit [63:0] spos;
    bit [31:0] win;
    target = $urandom_range(80, 6);
    n      = 0;
    while (n < target) begin
      kind = $urandom_range(99);
      len  = (kind < 45) ? $urandom_range(24, 1) :
             (kind < 85) ? $urandom_range(16, 1) : $urandom_range(4, 1);
      repeat (len) begin
        push_window(pick_prob(kind));
        n++;
      end
    end
    win  = 32'(model_cfg.window_len);
    spos = 64'(n) * 64'(win);
    kind = $urandom_range(99);
    if (kind < 70)      push_finish(32'(spos + 64'($urandom_range(3 * win))));
    else if (kind < 80) push_finish($urandom());
    else if (kind < 90) push_finish($urandom_range(spos[31:0]));
    else if (kind < 95) push_finish(32'd0);
    else                push_finish(32'hFFFF_FFFF);
    return n + 1;
  endfunction

  task automatic add_items(input int count);
    int n;
    n = 0;
    while (n < count) n += queue_stream();
  endtask

  // sender idle and every segment back, then let the back end settle
  task automatic wait_drained();
    do @(posedge clk);
    while (beats_to_send.size() != 0 || push || segs_due.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic load_regs(input vad_pkg::cfg_t c);
    logic [vad_pkg::CFG_IDX_W-1:0] idx[7] = '{vad_pkg::CFG_SPEECH_THRESHOLD,
                                              vad_pkg::CFG_MIN_SPEECH_LEN,
                                              vad_pkg::CFG_MAX_SPEECH_LEN,
                                              vad_pkg::CFG_MIN_SILENCE_LEN,
                                              vad_pkg::CFG_SPLIT_SILENCE_LEN,
                                              vad_pkg::CFG_PAD_LEN,
                                              vad_pkg::CFG_WINDOW_LEN};
    logic [31:0] val[7] = '{32'(c.speech_threshold), c.min_speech_len, c.max_speech_len,
                            c.min_silence_len, c.split_silence_len,
                            32'(c.pad_len), 32'(c.window_len)};
    for (int i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_wr   <= 1'b1;
      cfg_idx  <= idx[i];
      cfg_data <= val[i];
    end
    @(posedge clk);
    cfg_wr    <= 1'b0;
    model_cfg = c;
  endtask

  task automatic run_phase(input vad_pkg::cfg_t c, input idle_t m, input int count,
                           input bit long_stall, input bit mid_pause);
    load_regs(c);
    idle_mode <= m;
    if (long_stall) stall_req <= ~stall_req;
    if (mid_pause) begin
      add_items(count / 2);
      wait_drained();
      add_items(count - count / 2);
    end else begin
      add_items(count);
    end
    wait_drained();
  endtask

  // ---------------- sequence ----------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: threshold edges, a kept segment, a segment opened at zero,
    // end of stream with nothing to flush
    push_window(16'd0);
    repeat (8) push_window(16'hFFFF);
    push_window(16'd32768);
    push_window(16'd22938);
    repeat (5) push_window(16'd22937);
    repeat (5) push_window(16'hFFFF);
    push_finish(32'hFFFF_FFFF);
    push_finish(32'd0);
    push_window(16'hFFFF);
    push_finish(32'hFFFF_FFFF);
    wait_drained();

    run_phase(make_cfg(16'd32768, 32'd1000, 32'd6000, 32'd2500, 32'd800, 16'd300, 16'd512),
              IDLE_NONE, 250, 1'b0, 1'b1);
    run_phase(make_cfg(16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 16'd1),
              IDLE_TX, 200, 1'b0, 1'b0);
    run_phase(make_cfg(16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       16'hFFFF, 16'hFFFF), IDLE_BOTH, 200, 1'b0, 1'b0);
    run_phase(rand_cfg(), IDLE_RX, 250, 1'b1, 1'b0);
    run_phase(rand_cfg(), IDLE_BOTH, 200, 1'b0, 1'b0);
    run_phase(rand_cfg(), IDLE_NONE, 200, 1'b0, 1'b0);
    run_phase(make_cfg(16'd40000, 32'hFFFF_FFFF, 32'd4000, 32'd1000, 32'd500,
                       16'd100, 16'd256), IDLE_RX, 200, 1'b0, 1'b0);

    if (seg_errors == 0 && segs_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------- driver: one item beat per accepted push ----------------
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) advance_model(item);
      if (!(push && full)) begin
        if (beats_to_send.size() == 0 || roll(tx_idle_pct())) begin
          push <= 1'b0;
        end else begin
          item <= beats_to_send.pop_front();
          push <= 1'b1;
        end
      end
    end
  end

  // ---------------- monitor: check each segment beat ----------------
  always @(posedge clk) begin
    vad_pkg::result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (segs_due.size() == 0) begin
          seg_errors++;
          if (seg_errors <= 10)
            $display("ERROR: segment start %0d end %0d last %0b with none due",
                     result.seg_start, result.seg_end, result.last_of_run);
        end else begin
          want = segs_due.pop_front();
          if (result.seg_start !== want.seg_start || result.seg_end !== want.seg_end ||
              result.last_of_run !== want.last_of_run) begin
            seg_errors++;
            if (seg_errors <= 10)
              $display("ERROR: segment expected %0d..%0d last %0b, got %0d..%0d last %0b",
                       want.seg_start, want.seg_end, want.last_of_run,
                       result.seg_start, result.seg_end, result.last_of_run);
          end
        end
      end
      // long hold-off requested by the sequence
      if (stall_req != stall_ack) begin
        stall_ack  = stall_req;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= !roll(rx_idle_pct());
      end
    end
  end

  // ---------------- watchdog: no beat moving for too long ----------------
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> sim.f
rtl/vad_pkg.sv
rtl/vad_fifo.sv
rtl/vad_front.sv
rtl/vad_back.sv
rtl/vad_speech_segmenter.sv
tb/vad_speech_segmenter_tb.sv
